### rtl/ttfp_pkg.sv
// Shared types, constants and helper functions of the typed-table parser.
`default_nettype none
package ttfp_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int COL_W       = 12;
    localparam int NAME_BYTES  = 48;
    localparam logic [23:0] ROW_LIMIT     = 24'd10000000;
    localparam logic [31:0] VAR_TEXT_TYPE = 32'd26;

    typedef enum logic [3:0] {
        IK_VERSION = 4'd0,
        IK_NAME    = 4'd1,
        IK_COLDEF  = 4'd2,
        IK_ROW     = 4'd3,
        IK_NUMBER  = 4'd4,
        IK_TEXT    = 4'd5,
        IK_FEND    = 4'd6,
        IK_DONE    = 4'd7,
        IK_ERROR   = 4'd8
    } item_kind_t;

    typedef enum logic [3:0] {
        VK_U8     = 4'd0,
        VK_U16    = 4'd1,
        VK_U32    = 4'd2,
        VK_I8     = 4'd3,
        VK_I16    = 4'd4,
        VK_I32    = 4'd5,
        VK_FLOAT  = 4'd6,
        VK_STRING = 4'd7,
        VK_PAIR   = 4'd8,
        VK_RAW    = 4'd9
    } value_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_EARLY    = 2'd1,
        ERR_COUNTS   = 2'd2,
        ERR_MISMATCH = 2'd3
    } err_code_t;

    typedef enum logic [2:0] {
        ST_HEADER = 3'd0,
        ST_COLUMN = 3'd1,
        ST_ROWLEN = 3'd2,
        ST_FIELD  = 3'd3,
        ST_HALT   = 3'd4
    } parse_stage_t;

    typedef enum logic [2:0] {
        SQ_IDLE  = 3'd0,
        SQ_PROC  = 3'd1,
        SQ_FEND  = 3'd2,
        SQ_START = 3'd3,
        SQ_SCAN  = 3'd4,
        SQ_FIN   = 3'd5
    } seq_state_t;

    typedef struct packed {
        logic        vartext;
        logic [31:0] len;
        logic [3:0]  kind;
    } col_entry_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [11:0] col;
        logic [23:0] row;
        logic [3:0]  vk;
        logic [63:0] word;
        logic [7:0]  bval;
        logic [1:0]  err;
    } ttfp_item_t;

    // Map a column type code to its value kind
    function automatic logic [3:0] kind_of(input logic [31:0] t);
        logic [3:0] k;
        unique case (t)
            32'd1, 32'd12, 32'd16:          k = VK_U8;
            32'd2:                          k = VK_U16;
            32'd3, 32'd11, 32'd18, 32'd27:  k = VK_U32;
            32'd5:                          k = VK_FLOAT;
            32'd9, 32'd24, 32'd26:          k = VK_STRING;
            32'd13, 32'd21:                 k = VK_I16;
            32'd20:                         k = VK_I8;
            32'd22:                         k = VK_I32;
            32'd29:                         k = VK_PAIR;
            default:                        k = VK_RAW;
        endcase
        return k;
    endfunction

    // Bytes that one field of a column takes in a row
    function automatic logic [31:0] field_size(input col_entry_t e,
                                               input logic [31:0] vt_size);
        logic [31:0] s;
        unique case (e.kind)
            VK_U8, VK_I8:             s = 32'd1;
            VK_U16, VK_I16:           s = 32'd2;
            VK_U32, VK_I32, VK_FLOAT: s = 32'd4;
            VK_PAIR:                  s = 32'd8;
            VK_STRING:                s = e.vartext ? vt_size : e.len;
            default:                  s = e.len;
        endcase
        return s;
    endfunction

    function automatic ttfp_item_t make_item(input logic [3:0] kind,
                                             input logic [11:0] col,
                                             input logic [23:0] row,
                                             input logic [3:0] vk,
                                             input logic [63:0] word,
                                             input logic [7:0] bval,
                                             input logic [1:0] err);
        ttfp_item_t it;
        it.kind = kind;
        it.col  = col;
        it.row  = row;
        it.vk   = vk;
        it.word = word;
        it.bval = bval;
        it.err  = err;
        return it;
    endfunction

endpackage
`default_nettype wire

### rtl/ttfp_col_ram.sv
// Column table memory: one write port, one registered read port.
`default_nettype none
module ttfp_col_ram
    import ttfp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [COL_W-1:0] waddr,
    input  wire col_entry_t       wdata,
    input  wire logic [COL_W-1:0] raddr,
    output col_entry_t            rdata
);

    col_entry_t mem [MAX_COLUMNS];

    // Write one entry when we is high, read one entry every cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/ttfp_out_reg.sv
// Output register stage for result items.
`default_nettype none
module ttfp_out_reg
    import ttfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire ttfp_item_t  item,
    output logic             can_push,
    output logic             m_valid,
    input  wire logic        m_ready,
    output ttfp_item_t       m_item
);

    logic       valid_reg;
    ttfp_item_t item_reg;

    assign can_push = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_item   = item_reg;

    // Hold a result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg <= item;
        end
    end

endmodule
`default_nettype wire

### rtl/typed_table_file_parser.sv
// Typed-table content parser: one byte per transfer, up to three result items per byte.
// Each input byte is registered, and each result item is held in the output register for m_*.
// Each byte is processed, then as needed a field end or row check and a column scan that
//   skips zero-length columns (one column table read per cycle while results are accepted).
// After the final byte, the parser checks for early end and rearms; s_ready is high only in idle.
// Reset (aresetn low, synchronous): parser to header stage; column table not cleared.
`default_nettype none
module typed_table_file_parser
    import ttfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_final_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_item_kind,
    output logic [11:0]      m_column_index,
    output logic [23:0]      m_row_index,
    output logic [3:0]       m_value_kind,
    output logic [63:0]      m_word_value,
    output logic [7:0]       m_byte_value,
    output logic [1:0]       m_error_code
);

    seq_state_t   sq_reg, sq_next;
    parse_stage_t stage_reg, stage_next;
    logic [7:0]   byte_reg;
    logic         last_reg;
    logic [31:0]  fbc_reg, fbc_next;
    logic [63:0]  word_reg, word_next;
    logic [23:0]  rows_reg, rows_next;
    logic [12:0]  cols_reg, cols_next;
    logic [31:0]  rec_reg, rec_next;
    logic [44:0]  lsum_reg, lsum_next;
    logic [11:0]  col_reg, col_next;
    logic [23:0]  row_reg, row_next;
    logic [15:0]  rl_reg, rl_next;
    logic         te_reg, te_next;
    logic [3:0]   kind_reg, kind_next;
    logic [31:0]  size_reg, size_next;
    logic [12:0]  scan_reg, scan_next;

    logic         push, can_push;
    ttfp_item_t   item, m_item;
    logic         mem_we;
    col_entry_t   mem_wdata, rd_data;

    logic [2:0]   lane;
    logic         ins;
    logic [63:0]  wnew;
    logic [31:0]  col_off;
    logic [31:0]  vt_size;
    logic [31:0]  ent_size;
    logic         is_txt;
    logic         last_fb;
    logic         go_start, go_fend, go_scan, scan_skip;
    seq_state_t   after_byte;

    assign s_ready = (sq_reg == SQ_IDLE);

    ttfp_col_ram u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (col_reg),
        .wdata (mem_wdata),
        .raddr (scan_next[COL_W-1:0]),
        .rdata (rd_data)
    );

    ttfp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .item     (item),
        .can_push (can_push),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    assign m_item_kind    = m_item.kind;
    assign m_column_index = m_item.col;
    assign m_row_index    = m_item.row;
    assign m_value_kind   = m_item.vk;
    assign m_word_value   = m_item.word;
    assign m_byte_value   = m_item.bval;
    assign m_error_code   = m_item.err;

    // Byte lane that the current byte fills in the word assembler
    assign col_off = fbc_reg - 32'(NAME_BYTES);
    always_comb begin
        lane = 3'd0;
        ins  = 1'b0;
        unique case (stage_reg)
            ST_HEADER: begin
                lane = {1'b0, fbc_reg[1:0]};
                ins  = 1'b1;
            end
            ST_COLUMN: begin
                lane = col_off[2:0];
                ins  = (fbc_reg >= 32'(NAME_BYTES)) && (col_off < 32'd8);
            end
            ST_ROWLEN: begin
                lane = {2'b00, fbc_reg[0]};
                ins  = 1'b1;
            end
            ST_FIELD: begin
                lane = fbc_reg[2:0];
                ins  = (fbc_reg < 32'd8);
            end
            default: begin
                lane = 3'd0;
                ins  = 1'b0;
            end
        endcase
    end
    assign wnew = word_reg | (ins ? (64'(byte_reg) << {lane, 3'b000}) : 64'd0);

    // Size of a type-26 text field in the current row
    assign vt_size  = ({16'd0, rl_reg} >= rec_reg) ? ({16'd0, rl_reg} - rec_reg + 32'd1)
                                                   : 32'd1;
    assign ent_size = field_size(rd_data, vt_size);
    assign is_txt   = (kind_reg == VK_STRING) || (kind_reg == VK_RAW);
    assign last_fb  = ({1'b0, fbc_reg} + 33'd1) >= {1'b0, size_reg};
    assign after_byte = last_reg ? SQ_FIN : SQ_IDLE;

    // Parse datapath and result items
    always_comb begin
        stage_next = stage_reg;
        fbc_next   = fbc_reg;
        word_next  = word_reg;
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        rec_next   = rec_reg;
        lsum_next  = lsum_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        rl_next    = rl_reg;
        te_next    = te_reg;
        kind_next  = kind_reg;
        size_next  = size_reg;
        scan_next  = scan_reg;
        push       = 1'b0;
        item       = make_item(IK_VERSION, 12'd0, 24'd0, VK_U8, 64'd0, 8'd0, ERR_NONE);
        mem_we     = 1'b0;
        mem_wdata.vartext = (wnew[31:0] == VAR_TEXT_TYPE);
        mem_wdata.len     = wnew[63:32];
        mem_wdata.kind    = kind_of(wnew[31:0]);
        go_start   = 1'b0;
        go_fend    = 1'b0;
        go_scan    = 1'b0;
        scan_skip  = 1'b0;
        unique case (sq_reg)
            SQ_PROC: begin
                if (can_push) begin
                    unique case (stage_reg)
                        ST_HEADER: begin
                            word_next = wnew;
                            fbc_next  = {28'd0, fbc_reg[3:0]} + 32'd1;
                            if (fbc_reg[1:0] == 2'd3) begin
                                word_next = 64'd0;
                                unique case (fbc_reg[3:2])
                                    2'd0: begin
                                        push = 1'b1;
                                        item = make_item(IK_VERSION, 12'd0, 24'd0, VK_U8,
                                                         {32'd0, wnew[31:0]}, 8'd0, ERR_NONE);
                                    end
                                    2'd1: begin
                                        rows_next = (wnew[31:0] > {8'd0, ROW_LIMIT})
                                                    ? ROW_LIMIT + 24'd1 : wnew[23:0];
                                    end
                                    2'd2: begin
                                        rec_next = wnew[31:0];
                                    end
                                    default: begin
                                        if (wnew[31:0] > 32'(MAX_COLUMNS)
                                            || rows_reg > ROW_LIMIT) begin
                                            push = 1'b1;
                                            item = make_item(IK_ERROR, col_reg, row_reg,
                                                             VK_U8, 64'd0, 8'd0, ERR_COUNTS);
                                            stage_next = ST_HALT;
                                        end else begin
                                            cols_next = wnew[12:0];
                                            lsum_next = 45'd2;
                                            col_next  = 12'd0;
                                            if (wnew[31:0] == 32'd0) begin
                                                go_start = 1'b1;
                                            end else begin
                                                stage_next = ST_COLUMN;
                                                fbc_next   = 32'd0;
                                                te_next    = 1'b0;
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                        ST_COLUMN: begin
                            word_next = wnew;
                            fbc_next  = fbc_reg + 32'd1;
                            if (fbc_reg < 32'(NAME_BYTES) && !te_reg) begin
                                if (byte_reg == 8'd0) begin
                                    te_next = 1'b1;
                                end else begin
                                    push = 1'b1;
                                    item = make_item(IK_NAME, col_reg, 24'd0, VK_U8, 64'd0,
                                                     byte_reg, ERR_NONE);
                                end
                            end
                            if (fbc_reg == 32'(NAME_BYTES + 7)) begin
                                mem_we    = 1'b1;
                                lsum_next = lsum_reg + 45'(wnew[63:32]);
                                push      = 1'b1;
                                item      = make_item(IK_COLDEF, col_reg, 24'd0,
                                                      kind_of(wnew[31:0]), wnew, 8'd0,
                                                      ERR_NONE);
                                word_next = 64'd0;
                                fbc_next  = 32'd0;
                                te_next   = 1'b0;
                                if (({1'b0, col_reg} + 13'd1) >= cols_reg) begin
                                    col_next = 12'd0;
                                    go_start = 1'b1;
                                end else begin
                                    col_next = col_reg + 12'd1;
                                end
                            end
                        end
                        ST_ROWLEN: begin
                            word_next = wnew;
                            fbc_next  = fbc_reg + 32'd1;
                            if (fbc_reg[0]) begin
                                rl_next   = wnew[15:0];
                                push      = 1'b1;
                                item      = make_item(IK_ROW, 12'd0, row_reg, VK_U8,
                                                      {48'd0, wnew[15:0]}, 8'd0, ERR_NONE);
                                word_next = 64'd0;
                                scan_next = 13'd0;
                                go_scan   = 1'b1;
                            end
                        end
                        ST_FIELD: begin
                            fbc_next = fbc_reg + 32'd1;
                            if (is_txt) begin
                                if (kind_reg == VK_RAW || (!te_reg && byte_reg != 8'd0)) begin
                                    push = 1'b1;
                                    item = make_item(IK_TEXT, col_reg, row_reg, kind_reg,
                                                     64'd0, byte_reg, ERR_NONE);
                                end else if (!te_reg) begin
                                    te_next = 1'b1;
                                end
                                go_fend = last_fb;
                            end else begin
                                word_next = wnew;
                                if (last_fb) begin
                                    push      = 1'b1;
                                    item      = make_item(IK_NUMBER, col_reg, row_reg,
                                                          kind_reg, wnew, 8'd0, ERR_NONE);
                                    scan_next = {1'b0, col_reg} + 13'd1;
                                    go_scan   = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            SQ_FEND: begin
                if (can_push) begin
                    push      = 1'b1;
                    item      = make_item(IK_FEND, col_reg, row_reg, kind_reg, 64'd0, 8'd0,
                                          ERR_NONE);
                    scan_next = {1'b0, col_reg} + 13'd1;
                end
            end
            SQ_START: begin
                if (can_push) begin
                    if (lsum_reg != {13'd0, rec_reg}) begin
                        push       = 1'b1;
                        item       = make_item(IK_ERROR, col_reg, row_reg, VK_U8, 64'd0,
                                               8'd0, ERR_MISMATCH);
                        stage_next = ST_HALT;
                    end else if (rows_reg == 24'd0) begin
                        push       = 1'b1;
                        item       = make_item(IK_DONE, 12'd0, 24'd0, VK_U8, 64'd0, 8'd0,
                                               ERR_NONE);
                        stage_next = ST_HALT;
                    end else begin
                        row_next   = 24'd0;
                        stage_next = ST_ROWLEN;
                        fbc_next   = 32'd0;
                        word_next  = 64'd0;
                    end
                end
            end
            SQ_SCAN: begin
                if (can_push) begin
                    if (scan_reg >= cols_reg) begin
                        // Row complete
                        col_next = 12'd0;
                        if (({1'b0, row_reg} + 25'd1) >= {1'b0, rows_reg}) begin
                            push       = 1'b1;
                            item       = make_item(IK_DONE, 12'd0, 24'd0, VK_U8, 64'd0,
                                                   8'd0, ERR_NONE);
                            stage_next = ST_HALT;
                        end else begin
                            row_next   = row_reg + 24'd1;
                            stage_next = ST_ROWLEN;
                            fbc_next   = 32'd0;
                            word_next  = 64'd0;
                        end
                    end else if (ent_size == 32'd0) begin
                        // Skip a zero-length column
                        scan_skip = 1'b1;
                        scan_next = scan_reg + 13'd1;
                    end else begin
                        col_next   = scan_reg[COL_W-1:0];
                        stage_next = ST_FIELD;
                        fbc_next   = 32'd0;
                        word_next  = 64'd0;
                        te_next    = 1'b0;
                        kind_next  = rd_data.kind;
                        size_next  = ent_size;
                    end
                end
            end
            SQ_FIN: begin
                if (can_push) begin
                    if (stage_reg != ST_HALT) begin
                        push = 1'b1;
                        item = make_item(IK_ERROR, col_reg, row_reg, VK_U8, 64'd0, 8'd0,
                                         ERR_EARLY);
                    end
                    // Rearm for a new content
                    stage_next = ST_HEADER;
                    fbc_next   = 32'd0;
                    word_next  = 64'd0;
                    rows_next  = 24'd0;
                    cols_next  = 13'd0;
                    rec_next   = 32'd0;
                    lsum_next  = 45'd2;
                    col_next   = 12'd0;
                    row_next   = 24'd0;
                    rl_next    = 16'd0;
                    te_next    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        sq_next = sq_reg;
        unique case (sq_reg)
            SQ_IDLE: begin
                if (s_valid) begin
                    sq_next = SQ_PROC;
                end
            end
            SQ_PROC: begin
                if (can_push) begin
                    priority if (go_start) begin
                        sq_next = SQ_START;
                    end else if (go_fend) begin
                        sq_next = SQ_FEND;
                    end else if (go_scan) begin
                        sq_next = SQ_SCAN;
                    end else begin
                        sq_next = after_byte;
                    end
                end
            end
            SQ_FEND: begin
                if (can_push) begin
                    sq_next = SQ_SCAN;
                end
            end
            SQ_START: begin
                if (can_push) begin
                    sq_next = after_byte;
                end
            end
            SQ_SCAN: begin
                if (can_push && !scan_skip) begin
                    sq_next = after_byte;
                end
            end
            SQ_FIN: begin
                if (can_push) begin
                    sq_next = SQ_IDLE;
                end
            end
            default: begin
                sq_next = SQ_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg    <= SQ_IDLE;
            stage_reg <= ST_HEADER;
            fbc_reg   <= 32'd0;
            word_reg  <= 64'd0;
            rows_reg  <= 24'd0;
            cols_reg  <= 13'd0;
            rec_reg   <= 32'd0;
            lsum_reg  <= 45'd2;
            col_reg   <= 12'd0;
            row_reg   <= 24'd0;
            rl_reg    <= 16'd0;
            te_reg    <= 1'b0;
            scan_reg  <= 13'd0;
        end else begin
            sq_reg    <= sq_next;
            stage_reg <= stage_next;
            fbc_reg   <= fbc_next;
            word_reg  <= word_next;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            rec_reg   <= rec_next;
            lsum_reg  <= lsum_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            rl_reg    <= rl_next;
            te_reg    <= te_next;
            scan_reg  <= scan_next;
        end
    end

    // Capture the input byte and current field attributes
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
            last_reg <= s_final_byte;
        end
        kind_reg <= kind_next;
        size_reg <= size_next;
    end

endmodule
`default_nettype wire

### rtl/ttfp_checker.sv
// Port-level checks for the typed-table parser, bound to the top level.
`default_nettype none
module ttfp_checker
    import ttfp_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_item_kind,
    input wire logic [63:0] m_word_value,
    input wire logic [1:0]  m_error_code
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item_kind) && $stable(m_word_value))
        else $error("result changed while stalled");

    // Error items carry a code
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind == IK_ERROR |-> m_error_code != ERR_NONE)
        else $error("error item without code");

    // Other items carry no code
    a_no_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind != IK_ERROR |-> m_error_code == ERR_NONE)
        else $error("code on non-error item");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind typed_table_file_parser ttfp_checker u_ttfp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_item_kind  (m_item_kind),
    .m_word_value (m_word_value),
    .m_error_code (m_error_code)
);
`default_nettype wire
